// ===== rtl/rtod_pkg.sv =====
// rtod_pkg: shared types and constants for the regional trait ode derivative unit
// request and result payload structs, default parameter values, datapath widths
// no dependencies
package rtod_pkg;

  localparam int NUM_REGIONS_DEF = 5;
  localparam int RATE_WORDS_DEF  = 115;
  localparam int FRAC_BITS_DEF   = 32;

  localparam int VAL_W = 48;
  localparam int SUM_W = 53;
  localparam int TMP_W = 49;
  localparam int MOP_W = 54;
  localparam int DIG_W = MOP_W / 2;

  localparam logic [1:0] KIND_RATE = 2'd0;
  localparam logic [1:0] KIND_VAR  = 2'd1;
  localparam logic [1:0] KIND_EVAL = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [6:0]              slot;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [4:0]              deriv_index;
    logic signed [VAL_W-1:0] deriv_value;
    logic                    saturated;
    logic                    last;
  } out_t;

endpackage

// ===== rtl/regional_trait_ode_derivative_unit.sv =====
// regional_trait_ode_derivative_unit: top level, rate and variable memories,
// per-derivative sequencer and accumulators; depends on rtod_pkg and rtod_mul
//
//   channel | signals                              | moves
//   in      | in_valid_i, in_ready_o, in_req_i     | load rate, load variable, evaluate
//   out     | out_valid_o, out_ready_i, out_data_o | one derivative per result
//
// a load writes one word of the rate or variable memory; an evaluate gives 6*NUM_REGIONS results
// each derivative runs a step list of summed rates and products, the products going
// through the single shared iterative multiplier, plus setup, end step and emit
// no clearing pass after reset; a stalled output holds the next derivative back
module regional_trait_ode_derivative_unit #(
  parameter int NUM_REGIONS = rtod_pkg::NUM_REGIONS_DEF,
  parameter int RATE_WORDS  = rtod_pkg::RATE_WORDS_DEF,
  parameter int FRAC_BITS   = rtod_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rtod_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rtod_pkg::out_t out_data_o
);
  import rtod_pkg::*;

  localparam int BLOCK_WORDS = 11 + 3 * (NUM_REGIONS - 1);
  localparam int NUM_VARS    = 6 * NUM_REGIONS;
  localparam int NO  = 4 + NUM_REGIONS;
  localparam int NB  = NO + 1;
  localparam int NI  = NO + 3;
  localparam int SB  = NO + 2 + NUM_REGIONS;
  localparam int RAW = $clog2(RATE_WORDS);
  localparam int VAW = $clog2(NUM_VARS);
  localparam int RW  = $clog2(NUM_REGIONS);
  localparam int RKW = $clog2(BLOCK_WORDS);
  localparam int FIW = $clog2(NUM_REGIONS * BLOCK_WORDS);
  localparam int SW  = $clog2(SB + 11);

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_ISSUE, S_EXEC, S_MUL, S_EMIT} state_e;
  typedef enum logic [1:0] {OP_OUT, OP_ADDRATE, OP_MUL, OP_END} op_kind_e;
  typedef enum logic [1:0] {A_RATE, A_VARA, A_OUT, A_TMP} asrc_e;
  typedef enum logic [1:0] {B_VARB, B_TMP, B_TMP2} bsrc_e;
  typedef enum logic [1:0] {D_ACC_ADD, D_ACC_SUB, D_TMP_SET, D_TMP_ADD} dst_e;

  typedef struct packed {
    op_kind_e       kind;
    asrc_e          asrc;
    bsrc_e          bsrc;
    dst_e           dst;
    logic           rzero;
    logic [RKW-1:0] rk;
    logic [VAW-1:0] va;
    logic [VAW-1:0] vb;
  } uop_t;

  function automatic logic [VAW-1:0] vidx(input logic isd, input logic [RW-1:0] r,
                                          input logic [1:0] t);
    return VAW'(int'(isd) * 3 * NUM_REGIONS + 3 * int'(r) + int'(t));
  endfunction

  state_e               state_q;
  logic [SW-1:0]        step_q;
  logic                 isd_q;
  logic [RW-1:0]        r_q;
  logic [1:0]           t_q;
  logic [VAW-1:0]       didx_q;
  logic signed [SUM_W-1:0] acc_q, out_q;
  logic signed [TMP_W-1:0] tmp_q;
  logic                 clip_q;
  logic                 out_valid_q;
  out_t                 out_data_q;

  logic [VAL_W-1:0]     rate_mem [RATE_WORDS];
  logic [VAL_W-1:0]     var_mem  [NUM_VARS];
  logic [VAL_W-1:0]     rate_rd_q, va_q, vb_q;
  logic                 rok_q;

  uop_t                 uop;
  logic [FIW-1:0]       rate_full;
  logic                 rate_ok;
  logic [VAL_W-1:0]     rate_val;
  logic signed [MOP_W-1:0] mul_a, mul_b;
  logic                 mul_start, mul_done, mul_clip;
  logic signed [VAL_W-1:0] mul_p;
  logic signed [SUM_W-1:0] mul_ext, rate_ext;
  logic                 in_fire, acc_ovf, last_d;
  logic signed [VAL_W-1:0] sat_val;

  // step list of one derivative
  always_comb begin
    int s, j, p, rk_i;
    logic [RW-1:0] q;
    logic [1:0] o0, o1;
    logic [VAW-1:0] e0, e1, e01, d0, d1, d01, self_v;
    s  = int'(step_q);
    j  = s - SB;
    p  = s - NI;
    q  = (p >= int'(r_q)) ? RW'(p + 1) : RW'(p);
    o0 = (t_q == 2'd0) ? 2'd1 : 2'd0;
    o1 = (t_q == 2'd2) ? 2'd1 : 2'd2;
    e0  = vidx(1'b0, r_q, 2'd0);
    e1  = vidx(1'b0, r_q, 2'd1);
    e01 = vidx(1'b0, r_q, 2'd2);
    d0  = vidx(1'b1, r_q, 2'd0);
    d1  = vidx(1'b1, r_q, 2'd1);
    d01 = vidx(1'b1, r_q, 2'd2);
    self_v = vidx(isd_q, r_q, t_q);
    rk_i = 0;
    uop.kind  = OP_END;
    uop.asrc  = A_RATE;
    uop.bsrc  = B_VARB;
    uop.dst   = D_ACC_ADD;
    uop.rzero = 1'b0;
    uop.va    = self_v;
    uop.vb    = self_v;
    if (s < 5) begin
      uop.kind = OP_OUT;
      if (t_q == 2'd2) begin
        case (s)
          0:       rk_i = 2;
          1:       rk_i = 0;
          2:       rk_i = 1;
          3:       rk_i = 9;
          default: rk_i = 10;
        endcase
      end else begin
        case (s)
          0:       rk_i = int'(t_q);
          1:       rk_i = 3 + int'(t_q);
          2:       rk_i = 5 + 2 * int'(t_q);
          3:       rk_i = 6 + 2 * int'(t_q);
          default: uop.rzero = 1'b1;
        endcase
      end
    end else if (s < NO) begin
      uop.kind = OP_OUT;
      rk_i = 11 + int'(t_q) * (NUM_REGIONS - 1) + (s - 5);
    end else if (s == NO) begin
      uop.kind = OP_MUL;
      uop.asrc = A_OUT;
      uop.dst  = D_ACC_SUB;
    end else if (s < NI) begin
      uop.kind = OP_MUL;
      rk_i = 5 + 2 * int'(t_q) + (s - NB);
      uop.vb = vidx(isd_q, r_q, (s == NB) ? o0 : o1);
    end else if (s < SB) begin
      uop.kind = OP_MUL;
      rk_i = 11 + int'(t_q) * (NUM_REGIONS - 1) + p;
      uop.vb = vidx(isd_q, q, t_q);
    end else if (!isd_q && t_q != 2'd2) begin
      case (j)
        0: begin
          uop.kind = OP_ADDRATE;
          rk_i = 3 + int'(t_q);
        end
        1: begin
          uop.kind = OP_MUL;
          uop.dst  = D_TMP_SET;
          rk_i = int'(t_q);
        end
        2: begin
          uop.kind = OP_MUL;
          uop.asrc = A_TMP;
        end
        default: uop.kind = OP_END;
      endcase
    end else if (!isd_q) begin
      case (j)
        0: begin
          uop.kind = OP_MUL; uop.dst = D_TMP_SET; rk_i = 0; uop.vb = e0;
        end
        1: begin
          uop.kind = OP_MUL; uop.asrc = A_TMP; uop.vb = e01;
        end
        2: begin
          uop.kind = OP_MUL; uop.dst = D_TMP_SET; rk_i = 1; uop.vb = e01;
        end
        3: begin
          uop.kind = OP_MUL; uop.asrc = A_TMP; uop.vb = e1;
        end
        4: begin
          uop.kind = OP_MUL; uop.dst = D_TMP_SET; rk_i = 2; uop.vb = e0;
        end
        5: begin
          uop.kind = OP_MUL; uop.asrc = A_TMP; uop.vb = e1;
        end
        default: uop.kind = OP_END;
      endcase
    end else if (t_q != 2'd2) begin
      case (j)
        0: begin
          uop.kind = OP_MUL; uop.asrc = A_VARA; uop.dst = D_TMP_SET;
          uop.vb = vidx(1'b0, r_q, t_q);
        end
        1: begin
          uop.kind = OP_MUL; uop.bsrc = B_TMP2; rk_i = int'(t_q);
        end
        default: uop.kind = OP_END;
      endcase
    end else begin
      case (j)
        0: begin
          uop.kind = OP_MUL; uop.asrc = A_VARA; uop.dst = D_TMP_SET;
          uop.va = d0; uop.vb = e1;
        end
        1: begin
          uop.kind = OP_MUL; uop.asrc = A_VARA; uop.dst = D_TMP_ADD;
          uop.va = d1; uop.vb = e0;
        end
        2: begin
          uop.kind = OP_MUL; uop.bsrc = B_TMP; rk_i = 2;
        end
        3: begin
          uop.kind = OP_MUL; uop.asrc = A_VARA; uop.dst = D_TMP_SET;
          uop.va = e0; uop.vb = d01;
        end
        4: begin
          uop.kind = OP_MUL; uop.asrc = A_VARA; uop.dst = D_TMP_ADD;
          uop.va = e01; uop.vb = d0;
        end
        5: begin
          uop.kind = OP_MUL; uop.bsrc = B_TMP; rk_i = 0;
        end
        6: begin
          uop.kind = OP_MUL; uop.asrc = A_VARA; uop.dst = D_TMP_SET;
          uop.va = e1; uop.vb = d01;
        end
        7: begin
          uop.kind = OP_MUL; uop.asrc = A_VARA; uop.dst = D_TMP_ADD;
          uop.va = e01; uop.vb = d1;
        end
        8: begin
          uop.kind = OP_MUL; uop.bsrc = B_TMP; rk_i = 1;
        end
        default: uop.kind = OP_END;
      endcase
    end
    uop.rk = RKW'(rk_i);
  end

  assign rate_full = FIW'(r_q) * FIW'(BLOCK_WORDS) + FIW'(uop.rk);
  assign rate_ok   = !uop.rzero && (int'(rate_full) < RATE_WORDS);
  assign in_fire   = in_valid_i && in_ready_o;

  // rate table and variable store
  always_ff @(posedge clk_i) begin
    if (in_fire && in_req_i.kind == KIND_RATE && int'(in_req_i.slot) < RATE_WORDS) begin
      rate_mem[RAW'(in_req_i.slot)] <= in_req_i.value;
    end
    rate_rd_q <= rate_mem[RAW'(rate_full)];
    rok_q     <= rate_ok;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_req_i.kind == KIND_VAR && int'(in_req_i.slot) < NUM_VARS) begin
      var_mem[VAW'(in_req_i.slot)] <= in_req_i.value;
    end
    va_q <= var_mem[uop.va];
    vb_q <= var_mem[uop.vb];
  end

  assign rate_val = rok_q ? rate_rd_q : '0;
  assign rate_ext = {{(SUM_W-VAL_W){rate_val[VAL_W-1]}}, rate_val};

  always_comb begin
    unique case (uop.asrc)
      A_RATE:  mul_a = {{(MOP_W-VAL_W){rate_val[VAL_W-1]}}, rate_val};
      A_VARA:  mul_a = {{(MOP_W-VAL_W){va_q[VAL_W-1]}}, va_q};
      A_OUT:   mul_a = {{(MOP_W-SUM_W){out_q[SUM_W-1]}}, out_q};
      A_TMP:   mul_a = {{(MOP_W-TMP_W){tmp_q[TMP_W-1]}}, tmp_q};
      default: mul_a = '0;
    endcase
    unique case (uop.bsrc)
      B_VARB:  mul_b = {{(MOP_W-VAL_W){vb_q[VAL_W-1]}}, vb_q};
      B_TMP:   mul_b = {{(MOP_W-TMP_W){tmp_q[TMP_W-1]}}, tmp_q};
      B_TMP2:  mul_b = {{(MOP_W-TMP_W-1){tmp_q[TMP_W-1]}}, tmp_q, 1'b0};
      default: mul_b = '0;
    endcase
  end

  assign mul_start = (state_q == S_EXEC) && (uop.kind == OP_MUL);

  rtod_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p),
    .clip_o  (mul_clip)
  );

  assign mul_ext = {{(SUM_W-VAL_W){mul_p[VAL_W-1]}}, mul_p};
  assign acc_ovf = !((&acc_q[SUM_W-1:VAL_W-1]) || !(|acc_q[SUM_W-1:VAL_W-1]));
  assign sat_val = acc_ovf ? (acc_q[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                             : {1'b0, {(VAL_W-1){1'b1}}})
                           : acc_q[VAL_W-1:0];
  assign last_d  = (didx_q == VAW'(NUM_VARS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      isd_q       <= 1'b0;
      r_q         <= '0;
      t_q         <= '0;
      didx_q      <= '0;
      acc_q       <= '0;
      out_q       <= '0;
      tmp_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_req_i.kind == KIND_EVAL) begin
            isd_q   <= 1'b0;
            r_q     <= '0;
            t_q     <= '0;
            didx_q  <= '0;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          acc_q   <= '0;
          out_q   <= '0;
          tmp_q   <= '0;
          clip_q  <= 1'b0;
          step_q  <= '0;
          state_q <= S_ISSUE;
        end
        S_ISSUE: state_q <= S_EXEC;
        S_EXEC: begin
          unique case (uop.kind)
            OP_OUT: begin
              out_q   <= out_q + rate_ext;
              step_q  <= step_q + 1'b1;
              state_q <= S_ISSUE;
            end
            OP_ADDRATE: begin
              acc_q   <= acc_q + rate_ext;
              step_q  <= step_q + 1'b1;
              state_q <= S_ISSUE;
            end
            OP_MUL:  state_q <= S_MUL;
            default: state_q <= S_EMIT;
          endcase
        end
        S_MUL: begin
          if (mul_done) begin
            unique case (uop.dst)
              D_ACC_ADD: acc_q <= acc_q + mul_ext;
              D_ACC_SUB: acc_q <= acc_q - mul_ext;
              D_TMP_SET: tmp_q <= {mul_p[VAL_W-1], mul_p};
              default:   tmp_q <= tmp_q + {mul_p[VAL_W-1], mul_p};
            endcase
            clip_q  <= clip_q | mul_clip;
            step_q  <= step_q + 1'b1;
            state_q <= S_ISSUE;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q             <= 1'b1;
            out_data_q.deriv_index  <= 5'(didx_q);
            out_data_q.deriv_value  <= sat_val;
            out_data_q.saturated    <= clip_q | acc_ovf;
            out_data_q.last         <= last_d;
            didx_q                  <= didx_q + 1'b1;
            if (t_q == 2'd2) begin
              t_q <= '0;
              if (r_q == RW'(NUM_REGIONS - 1)) begin
                r_q   <= '0;
                isd_q <= 1'b1;
              end else begin
                r_q <= r_q + 1'b1;
              end
            end else begin
              t_q <= t_q + 2'd1;
            end
            state_q <= last_d ? S_IDLE : S_INIT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/rtod_mul.sv =====
// rtod_mul: iterative signed fixed-point multiplier, rounded and saturated to 48 bits
// four partial products of DIG_W x DIG_W bits, one per cycle, then a rounding step
// depends on rtod_pkg
module rtod_mul #(
  parameter int FRAC_BITS = rtod_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [rtod_pkg::MOP_W-1:0]    a_i,
  input  logic signed [rtod_pkg::MOP_W-1:0]    b_i,
  output logic                                 done_o,
  output logic signed [rtod_pkg::VAL_W-1:0]    p_o,
  output logic                                 clip_o
);
  import rtod_pkg::*;

  localparam int PW = 2 * MOP_W;

  logic [MOP_W-1:0]   ma_q, mb_q;
  logic               neg_q;
  logic [PW-1:0]      pacc_q;
  logic [2:0]         cnt_q;
  logic               busy_q, done_q, clip_q;
  logic signed [VAL_W-1:0] p_q;

  logic [DIG_W-1:0]   da, db;
  logic [2*DIG_W-1:0] pp;
  logic [PW-1:0]      pp_ext, pp_sh;
  logic [PW:0]        rnd, sh, lim;
  logic               ovf;
  logic [VAL_W-1:0]   mag;

  assign da = cnt_q[1] ? ma_q[MOP_W-1:DIG_W] : ma_q[DIG_W-1:0];
  assign db = cnt_q[0] ? mb_q[MOP_W-1:DIG_W] : mb_q[DIG_W-1:0];
  assign pp = {{DIG_W{1'b0}}, da} * {{DIG_W{1'b0}}, db};
  assign pp_ext = {{(PW-2*DIG_W){1'b0}}, pp};

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    pp_sh = pp_ext;
      2'd3:    pp_sh = pp_ext << (2 * DIG_W);
      default: pp_sh = pp_ext << DIG_W;
    endcase
  end

  assign rnd = {1'b0, pacc_q} + ((PW+1)'(1) << (FRAC_BITS - 1));
  assign sh  = rnd >> FRAC_BITS;
  assign lim = neg_q ? ((PW+1)'(1) << (VAL_W - 1)) : (((PW+1)'(1) << (VAL_W - 1)) - 1'b1);
  assign ovf = sh > lim;
  assign mag = ovf ? lim[VAL_W-1:0] : sh[VAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ma_q   <= '0;
      mb_q   <= '0;
      neg_q  <= 1'b0;
      pacc_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      clip_q <= 1'b0;
      p_q    <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 3'd4);
      if (start_i) begin
        ma_q   <= a_i[MOP_W-1] ? MOP_W'(-a_i) : MOP_W'(a_i);
        mb_q   <= b_i[MOP_W-1] ? MOP_W'(-b_i) : MOP_W'(b_i);
        neg_q  <= a_i[MOP_W-1] ^ b_i[MOP_W-1];
        pacc_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q != 3'd4) begin
          pacc_q <= pacc_q + pp_sh;
          cnt_q  <= cnt_q + 3'd1;
        end else begin
          p_q    <= neg_q ? -$signed(mag) : $signed(mag);
          clip_q <= ovf;
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;
  assign clip_o = clip_q;

endmodule

// ===== rtl/rtod_checker.sv =====
// rtod_checker: port-level checks for the regional trait ode derivative unit
// bound to the top level below; depends on rtod_pkg
module rtod_checker #(
  parameter int NUM_REGIONS = rtod_pkg::NUM_REGIONS_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input rtod_pkg::in_t  in_req_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rtod_pkg::out_t out_data_o
);
  import rtod_pkg::*;

  localparam logic [4:0] LAST_IDX = 5'(6 * NUM_REGIONS - 1);

  // output holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // evaluate request closes the input until the derivatives are done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_req_i.kind == KIND_EVAL |=> !in_ready_o)
    else $error("input open during evaluation");

  // last flag marks exactly the final index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.deriv_index == LAST_IDX)))
    else $error("last flag mismatch");

  // results follow in index order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last ##1 out_valid_o |->
      out_data_o.deriv_index == $past(out_data_o.deriv_index) + 5'd1)
    else $error("derivative index out of order");

endmodule

bind regional_trait_ode_derivative_unit rtod_checker #(
  .NUM_REGIONS (NUM_REGIONS)
) u_rtod_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
